FILE: hw/rtl/vcrd_pkg.sv
// shared types and constants for the vector clock race detector
package vcrd_pkg;

    localparam int NODES   = 256;
    localparam int CHAINS  = 16;
    localparam int VARS    = 1024;
    localparam int NODE_W  = 8;
    localparam int CHAIN_W = 4;
    localparam int TIME_W  = 9;
    localparam int VAR_W   = 10;
    localparam int NADDR_W = NODE_W + CHAIN_W;
    localparam int OADDR_W = CHAIN_W + NODE_W;
    localparam int RADDR_W = VAR_W + CHAIN_W;
    localparam int CLR_W   = RADDR_W;

    typedef struct packed {
        logic [CHAIN_W-1:0] chain;
        logic [TIME_W-1:0]  time_v;
    } epoch_t;

    localparam int EPOCH_W = $bits(epoch_t);

    typedef enum logic [2:0] {
        CMD_BEGIN = 3'd0,
        CMD_END   = 3'd1,
        CMD_ARC   = 3'd2,
        CMD_READ  = 3'd3,
        CMD_WRITE = 3'd4,
        CMD_SYNC  = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_DONE  = 2'd0,
        KIND_RACE  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_NESTED    = 3'd1,
        ERR_ORDER     = 3'd2,
        ERR_NOT_IN    = 3'd3,
        ERR_AFTER_OPS = 3'd4,
        ERR_BACKWARDS = 3'd5,
        ERR_NO_CHAIN  = 3'd6
    } err_t;

    typedef enum logic [21:0] {
        ST_IDLE    = 22'd1,
        ST_DECODE  = 22'd2,
        ST_ARC_A   = 22'd4,
        ST_ARC_B   = 22'd8,
        ST_ARC_W   = 22'd16,
        ST_SRCH_RD = 22'd32,
        ST_SRCH_CK = 22'd64,
        ST_LD0     = 22'd128,
        ST_LD1     = 22'd256,
        ST_LD2     = 22'd512,
        ST_W_CK    = 22'd1024,
        ST_W_EMIT  = 22'd2048,
        ST_V_RD    = 22'd4096,
        ST_V_CK    = 22'd8192,
        ST_V_EMIT  = 22'd16384,
        ST_R_RD    = 22'd32768,
        ST_R_CK    = 22'd65536,
        ST_R_EMIT  = 22'd131072,
        ST_W_FIN   = 22'd262144,
        ST_RD_UPD  = 22'd524288,
        ST_RD_UPD2 = 22'd1048576,
        ST_FINISH  = 22'd2097152
    } state_t;

endpackage

FILE: hw/rtl/vector_clock_race_detector_top.sv
// top level of the vector clock race detector
// Takes one command transaction at a time and answers with zero or more race
// transactions followed by one done or error transaction flagged with last.
// After reset a clearing pass zeroes the clock, epoch and read-vector
// memories and marks every epoch owner unknown; no command is taken
// meanwhile. Begin, end and unknown commands go from decode straight to the
// closing transaction; arcs and syncs walk every clock component through
// the single node-clock memory port. A read needs an extra update state when
// a second reader widens the read epoch into a vector. A write checks a
// single read epoch, or meets a shared read vector and walks all 16
// components. The first access of an event first runs the chain search over
// the clock components. Waiting for the result side to take a transaction
// can stall a race or closing transaction.
module vector_clock_race_detector_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [2:0]                    s_command,
    input  logic [vcrd_pkg::NODE_W-1:0]   s_event_id,
    input  logic [vcrd_pkg::NODE_W-1:0]   s_second_event,
    input  logic [vcrd_pkg::VAR_W-1:0]    s_variable,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_kind,
    output logic [2:0]                    m_error_code,
    output logic                          m_earlier_was_write,
    output logic signed [8:0]             m_earlier_event,
    output logic                          m_later_was_write,
    output logic [vcrd_pkg::NODE_W-1:0]   m_later_event,
    output logic                          m_last
);
    import vcrd_pkg::*;

    // sequencer and per-transaction context
    state_t                state_reg, state_next;
    logic [2:0]            cmd_reg, cmd_next;
    logic [NODE_W-1:0]     id_reg, id_next;
    logic [NODE_W-1:0]     id2_reg, id2_next;
    logic [VAR_W-1:0]      var_reg, var_next;
    logic [CHAIN_W-1:0]    idx_reg, idx_next;
    logic [NODE_W-1:0]     arc_a_reg, arc_a_next;
    logic [NODE_W-1:0]     arc_b_reg, arc_b_next;
    logic [TIME_W-1:0]     aval_reg, aval_next;
    err_t                  err_reg, err_next;

    // architectural state held in flops
    logic signed [8:0]     cur_reg, cur_next;
    logic                  in_event_reg, in_event_next;
    logic                  had_ops_reg, had_ops_next;
    logic [NODES-1:0]      chain_valid_reg, chain_valid_next;
    logic [TIME_W-1:0]     max_clock_reg [CHAINS];
    logic [TIME_W-1:0]     max_clock_next [CHAINS];

    // access context
    logic [CHAIN_W-1:0]    c_reg, c_next;
    logic [TIME_W-1:0]     vc_reg, vc_next;
    epoch_t                w_reg, w_next;
    epoch_t                r_reg, r_next;
    logic                  sh_reg, sh_next;
    logic                  race_reg, race_next;
    logic [TIME_W-1:0]     rvv_reg, rvv_next;

    // clearing pass after reset
    logic                  clear_reg;
    logic [CLR_W-1:0]      clear_cnt_reg;

    // result register
    logic                  m_valid_reg;
    logic                  out_free;
    logic                  emit;
    kind_t                 emit_kind;
    err_t                  emit_code;
    logic                  emit_ew;
    logic signed [8:0]     emit_ee;
    logic                  emit_last;

    // memory ports
    logic                  nc_we;
    logic [NADDR_W-1:0]    nc_waddr, nc_raddr;
    logic [TIME_W-1:0]     nc_wdata, nc_rdata;
    logic                  ch_we;
    logic [NODE_W-1:0]     ch_waddr, ch_raddr;
    logic [CHAIN_W-1:0]    ch_wdata, ch_rdata;
    logic                  ow_we;
    logic [OADDR_W-1:0]    ow_waddr, ow_raddr;
    logic [8:0]            ow_wdata, ow_rdata;
    logic                  we_we;
    logic [VAR_W-1:0]      we_waddr;
    epoch_t                we_wdata, we_rdata;
    logic                  re_we;
    logic [VAR_W-1:0]      re_waddr;
    epoch_t                re_wdata, re_rdata;
    logic                  sh_we;
    logic [VAR_W-1:0]      sh_waddr;
    logic                  sh_wdata, sh_rdata;
    logic                  rv_we;
    logic [RADDR_W-1:0]    rv_waddr, rv_raddr;
    logic [TIME_W-1:0]     rv_wdata, rv_rdata;

    logic [NODE_W-1:0]     slot;
    logic                  is_write;
    logic                  last_idx;

    assign slot     = cur_reg[NODE_W-1:0];
    assign is_write = (cmd_reg == CMD_WRITE);
    assign last_idx = (idx_reg == CHAIN_W'(CHAINS - 1));
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && !clear_reg;
    assign m_valid  = m_valid_reg;

    vcrd_ram #(.WIDTH(TIME_W), .DEPTH(NODES * CHAINS)) u_node_clock (
        .aclk(aclk), .we(nc_we), .waddr(nc_waddr), .wdata(nc_wdata),
        .raddr(nc_raddr), .rdata(nc_rdata)
    );
    vcrd_ram #(.WIDTH(CHAIN_W), .DEPTH(NODES)) u_node_chain (
        .aclk(aclk), .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
        .raddr(ch_raddr), .rdata(ch_rdata)
    );
    vcrd_ram #(.WIDTH(9), .DEPTH(CHAINS * NODES)) u_epoch_owner (
        .aclk(aclk), .we(ow_we), .waddr(ow_waddr), .wdata(ow_wdata),
        .raddr(ow_raddr), .rdata(ow_rdata)
    );
    vcrd_ram #(.WIDTH(EPOCH_W), .DEPTH(VARS)) u_write_epoch (
        .aclk(aclk), .we(we_we), .waddr(we_waddr), .wdata(we_wdata),
        .raddr(var_reg), .rdata(we_rdata)
    );
    vcrd_ram #(.WIDTH(EPOCH_W), .DEPTH(VARS)) u_read_epoch (
        .aclk(aclk), .we(re_we), .waddr(re_waddr), .wdata(re_wdata),
        .raddr(var_reg), .rdata(re_rdata)
    );
    vcrd_ram #(.WIDTH(1), .DEPTH(VARS)) u_read_shared (
        .aclk(aclk), .we(sh_we), .waddr(sh_waddr), .wdata(sh_wdata),
        .raddr(var_reg), .rdata(sh_rdata)
    );
    vcrd_ram #(.WIDTH(TIME_W), .DEPTH(VARS * CHAINS)) u_read_vector (
        .aclk(aclk), .we(rv_we), .waddr(rv_waddr), .wdata(rv_wdata),
        .raddr(rv_raddr), .rdata(rv_rdata)
    );

    // sequencer: next state, memory ports and result load
    always_comb begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        id_next          = id_reg;
        id2_next         = id2_reg;
        var_next         = var_reg;
        idx_next         = idx_reg;
        arc_a_next       = arc_a_reg;
        arc_b_next       = arc_b_reg;
        aval_next        = aval_reg;
        err_next         = err_reg;
        cur_next         = cur_reg;
        in_event_next    = in_event_reg;
        had_ops_next     = had_ops_reg;
        chain_valid_next = chain_valid_reg;
        max_clock_next   = max_clock_reg;
        c_next           = c_reg;
        vc_next          = vc_reg;
        w_next           = w_reg;
        r_next           = r_reg;
        sh_next          = sh_reg;
        race_next        = race_reg;
        rvv_next         = rvv_reg;

        nc_we = 1'b0; nc_waddr = '0; nc_wdata = '0; nc_raddr = '0;
        ch_we = 1'b0; ch_waddr = '0; ch_wdata = '0; ch_raddr = slot;
        ow_we = 1'b0; ow_waddr = '0; ow_wdata = '0; ow_raddr = '0;
        we_we = 1'b0; we_waddr = var_reg; we_wdata = '0;
        re_we = 1'b0; re_waddr = var_reg; re_wdata = '0;
        sh_we = 1'b0; sh_waddr = var_reg; sh_wdata = 1'b0;
        rv_we = 1'b0; rv_waddr = '0; rv_wdata = '0; rv_raddr = '0;

        emit      = 1'b0;
        emit_kind = KIND_RACE;
        emit_code = ERR_NONE;
        emit_ew   = 1'b0;
        emit_ee   = ow_rdata;
        emit_last = 1'b0;

        if (clear_reg) begin
            // sweep every memory but the node-chain memory back to its reset contents
            nc_we = 1'b1; nc_waddr = clear_cnt_reg[NADDR_W-1:0];
            ow_we = 1'b1; ow_waddr = clear_cnt_reg[OADDR_W-1:0]; ow_wdata = '1;
            we_we = 1'b1; we_waddr = clear_cnt_reg[VAR_W-1:0];
            re_we = 1'b1; re_waddr = clear_cnt_reg[VAR_W-1:0];
            sh_we = 1'b1; sh_waddr = clear_cnt_reg[VAR_W-1:0];
            rv_we = 1'b1; rv_waddr = clear_cnt_reg;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd_next   = s_command;
                    id_next    = s_event_id;
                    id2_next   = s_second_event;
                    var_next   = s_variable;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                err_next   = ERR_NONE;
                idx_next   = '0;
                state_next = ST_FINISH;
                case (cmd_reg)
                    CMD_BEGIN: begin
                        if (in_event_reg) begin
                            err_next = ERR_NESTED;
                        end else if (cur_reg >= $signed({1'b0, id_reg})) begin
                            err_next = ERR_ORDER;
                        end else begin
                            in_event_next = 1'b1;
                            cur_next      = $signed({1'b0, id_reg});
                            had_ops_next  = 1'b0;
                        end
                    end
                    CMD_END: begin
                        if (!in_event_reg) begin
                            err_next = ERR_NOT_IN;
                        end else begin
                            in_event_next = 1'b0;
                        end
                    end
                    CMD_ARC: begin
                        if (!in_event_reg) begin
                            err_next = ERR_NOT_IN;
                        end else if (had_ops_reg) begin
                            err_next = ERR_AFTER_OPS;
                        end else if (id_reg >= slot) begin
                            err_next = ERR_BACKWARDS;
                        end else begin
                            arc_a_next = id_reg;
                            arc_b_next = slot;
                            state_next = ST_ARC_A;
                        end
                    end
                    CMD_SYNC: begin
                        if (id_reg >= id2_reg) begin
                            err_next = ERR_BACKWARDS;
                        end else begin
                            arc_a_next = id_reg;
                            arc_b_next = id2_reg;
                            state_next = ST_ARC_A;
                        end
                    end
                    CMD_READ, CMD_WRITE: begin
                        if (!in_event_reg) begin
                            err_next = ERR_NOT_IN;
                        end else if (!had_ops_reg && !chain_valid_reg[slot]) begin
                            state_next = ST_SRCH_RD;
                        end else begin
                            had_ops_next = 1'b1;
                            state_next   = ST_LD0;
                        end
                    end
                    default: begin
                        err_next = ERR_NONE;
                    end
                endcase
            end
            // arc: later clock takes the componentwise max
            ST_ARC_A: begin
                nc_raddr   = {arc_a_reg, idx_reg};
                state_next = ST_ARC_B;
            end
            ST_ARC_B: begin
                aval_next  = nc_rdata;
                nc_raddr   = {arc_b_reg, idx_reg};
                state_next = ST_ARC_W;
            end
            ST_ARC_W: begin
                if (aval_reg > nc_rdata) begin
                    nc_we    = 1'b1;
                    nc_waddr = {arc_b_reg, idx_reg};
                    nc_wdata = aval_reg;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = last_idx ? ST_FINISH : ST_ARC_A;
            end
            // chain search on the first access of an event
            ST_SRCH_RD: begin
                nc_raddr   = {slot, idx_reg};
                state_next = ST_SRCH_CK;
            end
            ST_SRCH_CK: begin
                if (nc_rdata == max_clock_reg[idx_reg]) begin
                    nc_we    = 1'b1;
                    nc_waddr = {slot, idx_reg};
                    nc_wdata = nc_rdata + 1'b1;
                    max_clock_next[idx_reg] = max_clock_reg[idx_reg] + 1'b1;
                    ch_we    = 1'b1;
                    ch_waddr = slot;
                    ch_wdata = idx_reg;
                    // new epoch time is old time plus one, stored at time minus one
                    ow_we    = 1'b1;
                    ow_waddr = {idx_reg, nc_rdata[NODE_W-1:0]};
                    ow_wdata = {1'b0, slot};
                    chain_valid_next[slot] = 1'b1;
                    had_ops_next = 1'b1;
                    state_next   = ST_LD0;
                end else if (last_idx) begin
                    err_next   = ERR_NO_CHAIN;
                    state_next = ST_FINISH;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SRCH_RD;
                end
            end
            // load chain, own time and variable epochs
            ST_LD0: begin
                ch_raddr   = slot;
                state_next = ST_LD1;
            end
            ST_LD1: begin
                c_next     = ch_rdata;
                nc_raddr   = {slot, ch_rdata};
                state_next = ST_LD2;
            end
            ST_LD2: begin
                vc_next    = nc_rdata;
                w_next     = we_rdata;
                r_next     = re_rdata;
                sh_next    = sh_rdata;
                nc_raddr   = {slot, we_rdata.chain};
                state_next = ST_W_CK;
            end
            // check against the last write
            ST_W_CK: begin
                race_next  = (w_reg.time_v > nc_rdata);
                ow_raddr   = {w_reg.chain, NODE_W'(w_reg.time_v - 1'b1)};
                state_next = ST_W_EMIT;
            end
            ST_W_EMIT: begin
                ow_raddr = {w_reg.chain, NODE_W'(w_reg.time_v - 1'b1)};
                if (!race_reg || out_free) begin
                    emit    = race_reg;
                    emit_ew = 1'b1;
                    idx_next = '0;
                    if (!is_write) begin
                        state_next = ST_RD_UPD;
                    end else if (sh_reg) begin
                        state_next = ST_V_RD;
                    end else begin
                        state_next = ST_R_RD;
                    end
                end
            end
            // write against a shared read vector, clearing it as it goes
            ST_V_RD: begin
                nc_raddr   = {slot, idx_reg};
                rv_raddr   = {var_reg, idx_reg};
                state_next = ST_V_CK;
            end
            ST_V_CK: begin
                race_next  = (rv_rdata > nc_rdata);
                rvv_next   = rv_rdata;
                ow_raddr   = {idx_reg, NODE_W'(rv_rdata - 1'b1)};
                rv_we      = 1'b1;
                rv_waddr   = {var_reg, idx_reg};
                rv_wdata   = '0;
                state_next = ST_V_EMIT;
            end
            ST_V_EMIT: begin
                ow_raddr = {idx_reg, NODE_W'(rvv_reg - 1'b1)};
                if (!race_reg || out_free) begin
                    emit       = race_reg;
                    idx_next   = idx_reg + 1'b1;
                    state_next = last_idx ? ST_W_FIN : ST_V_RD;
                end
            end
            // write against a single read epoch
            ST_R_RD: begin
                nc_raddr   = {slot, r_reg.chain};
                ow_raddr   = {r_reg.chain, NODE_W'(r_reg.time_v - 1'b1)};
                state_next = ST_R_CK;
            end
            ST_R_CK: begin
                race_next  = (r_reg.time_v > nc_rdata);
                ow_raddr   = {r_reg.chain, NODE_W'(r_reg.time_v - 1'b1)};
                state_next = ST_R_EMIT;
            end
            ST_R_EMIT: begin
                ow_raddr = {r_reg.chain, NODE_W'(r_reg.time_v - 1'b1)};
                if (!race_reg || out_free) begin
                    emit       = race_reg;
                    state_next = ST_W_FIN;
                end
            end
            ST_W_FIN: begin
                sh_we      = 1'b1;
                sh_wdata   = 1'b0;
                re_we      = 1'b1;
                re_wdata   = '0;
                we_we      = 1'b1;
                we_wdata   = '{chain: c_reg, time_v: vc_reg};
                state_next = ST_FINISH;
            end
            // record a read
            ST_RD_UPD: begin
                state_next = ST_FINISH;
                if (sh_reg) begin
                    rv_we    = 1'b1;
                    rv_waddr = {var_reg, c_reg};
                    rv_wdata = vc_reg;
                end else if (r_reg.time_v == '0) begin
                    re_we    = 1'b1;
                    re_wdata = '{chain: c_reg, time_v: vc_reg};
                end else begin
                    rv_we      = 1'b1;
                    rv_waddr   = {var_reg, r_reg.chain};
                    rv_wdata   = r_reg.time_v;
                    state_next = ST_RD_UPD2;
                end
            end
            ST_RD_UPD2: begin
                rv_we      = 1'b1;
                rv_waddr   = {var_reg, c_reg};
                rv_wdata   = vc_reg;
                sh_we      = 1'b1;
                sh_wdata   = 1'b1;
                state_next = ST_FINISH;
            end
            // closing transaction
            ST_FINISH: begin
                if (out_free) begin
                    emit       = 1'b1;
                    emit_kind  = (err_reg == ERR_NONE) ? KIND_DONE : KIND_ERROR;
                    emit_code  = err_reg;
                    emit_ee    = '0;
                    emit_last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            cur_reg         <= '1;
            in_event_reg    <= 1'b0;
            had_ops_reg     <= 1'b0;
            chain_valid_reg <= '0;
            for (int i = 0; i < CHAINS; i++) begin
                max_clock_reg[i] <= '0;
            end
            err_reg         <= ERR_NONE;
            clear_reg       <= 1'b1;
            clear_cnt_reg   <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            cur_reg         <= cur_next;
            in_event_reg    <= in_event_next;
            had_ops_reg     <= had_ops_next;
            chain_valid_reg <= chain_valid_next;
            max_clock_reg   <= max_clock_next;
            err_reg         <= err_next;
            if (clear_reg) begin
                clear_cnt_reg <= clear_cnt_reg + 1'b1;
                if (clear_cnt_reg == '1) begin
                    clear_reg <= 1'b0;
                end
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // context and result payload
    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        id_reg    <= id_next;
        id2_reg   <= id2_next;
        var_reg   <= var_next;
        idx_reg   <= idx_next;
        arc_a_reg <= arc_a_next;
        arc_b_reg <= arc_b_next;
        aval_reg  <= aval_next;
        c_reg     <= c_next;
        vc_reg    <= vc_next;
        w_reg     <= w_next;
        r_reg     <= r_next;
        sh_reg    <= sh_next;
        race_reg  <= race_next;
        rvv_reg   <= rvv_next;
        if (emit) begin
            m_kind              <= emit_kind;
            m_error_code        <= emit_code;
            m_earlier_was_write <= emit_ew;
            m_earlier_event     <= emit_ee;
            m_later_was_write   <= emit_last ? 1'b0 : is_write;
            m_later_event       <= emit_last ? '0 : slot;
            m_last              <= emit_last;
        end
    end

    a_no_take_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_reg |-> !s_ready)
        else $error("command taken during clearing pass");
    a_close_has_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind != KIND_RACE) |-> m_last)
        else $error("done or error transaction without last");
    a_race_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_RACE) |-> !m_last)
        else $error("race transaction flagged last");
    a_error_has_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_ERROR) |-> m_error_code != ERR_NONE)
        else $error("error transaction with no code");
    a_open_event_known: assert property (@(posedge aclk) disable iff (!aresetn)
        in_event_reg |-> !cur_reg[8])
        else $error("open event without an event id");
endmodule

FILE: hw/rtl/vcrd_ram.sv
// generic single write port ram with registered read
module vcrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
